FILE: rtl/core/ctfc_pkg.sv
// Package for the cable test frame checker: beat payload types, core state
// codes, fault flag positions and the CRC-8 byte update. No dependencies.
package ctfc_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic       report_kind;
      logic [7:0] core_index;
      logic [2:0] core_state;
      logic [4:0] miswire_target;
      logic [7:0] cable_number;
      logic       crc_ok;
      logic       any_open;
      logic       any_short;
      logic       any_miswire;
      logic       cable_healthy;
      logic       last_of_run;
   } rsp_type;

   // report kinds
   localparam logic KIND_CORE    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // core state codes
   localparam logic [2:0] CORE_OK        = 3'd0;
   localparam logic [2:0] CORE_SHORT     = 3'd1;
   localparam logic [2:0] CORE_OPEN      = 3'd2;
   localparam logic [2:0] CORE_MISWIRED  = 3'd3;
   localparam logic [2:0] CORE_NOT_CONN  = 3'd4;
   localparam logic [2:0] CORE_UNKNOWN   = 3'd5;
   localparam logic [2:0] CORE_CODE_MASK = 3'b111;

   // fault flag bit positions
   localparam int FLAG_OPEN    = 0;
   localparam int FLAG_SHORT   = 1;
   localparam int FLAG_MISWIRE = 2;

   // frame byte positions
   localparam logic [2:0] POS_CABLE = 3'd2;
   localparam logic [2:0] POS_CORE  = 3'd3;
   localparam logic [2:0] POS_SAT   = 3'd4;

   localparam logic [7:0] CRC_POLY = 8'h07;

   // CRC-8, polynomial 0x07, MSB first, one byte per call
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

endpackage

FILE: rtl/core/cable_test_frame_checker.sv
// Cable test frame checker top level: frame parse, CRC check and a three
// entry result queue. Depends on ctfc_pkg.
//
// Usage:
//   req channel: one frame byte per beat (req_data.data_byte), with
//   req_data.last_byte high on the trailing CRC byte that ends the frame.
//   rsp channel: one report per beat. Bytes from index 3 up to the byte
//   before the CRC each give a core report; the CRC byte gives a frame
//   summary with the CRC match, fault flags and health.
//   A core report is held until the next byte shows it is not the CRC, so
//   it leaves on the beat of the following byte. A CRC byte that follows a
//   core byte gives two reports (core, then summary).
//   Reports pass through the registered result queue, so a report reaches
//   rsp only after the byte that releases it has been accepted.
//   Throughput: one byte per cycle while req_ready is high. The rate is set
//   by the result queue: req_ready is high while at most one report is
//   queued, so a frame end that pushes two reports can stall req while the queue drains.
//   Stall: when rsp_ready is low the queue fills and req_ready drops; no
//   report is lost or repeated.
//   Reset (synchronous, active high) clears the frame state and empties the
//   queue; the next byte is taken as index 0 of a new frame.
module cable_test_frame_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ctfc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ctfc_pkg::rsp_type rsp_data
);

   localparam logic [1:0] QUEUE_LAST = 2'd2;
   localparam logic [1:0] QUEUE_FULL = 2'd3;

   // frame state
   logic [7:0] crc_ff, crc_in;
   logic [2:0] pos_ff, pos_in;
   logic [7:0] held_ff, held_in;
   logic       held_valid_ff, held_valid_in;
   logic [7:0] cable_ff, cable_in;
   logic [7:0] count_ff, count_in;
   logic [2:0] flags_ff, flags_in;

   // result queue
   ctfc_pkg::rsp_type queue_ff [0:2];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;

   logic req_fire, rsp_fire;
   logic push_core, push_sum;
   ctfc_pkg::rsp_type core_rsp, sum_rsp;
   logic [2:0] code;
   logic [2:0] flags_core;
   logic       crc_match;

   function automatic logic [1:0] ptr_next(input logic [1:0] p);
      return (p == QUEUE_LAST) ? 2'd0 : p + 2'd1;
   endfunction

   assign req_ready = (fill_ff <= 2'd1);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = (fill_ff != 2'd0);
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign rsp_data  = queue_ff[rd_ptr_ff];

   assign push_core = req_fire && held_valid_ff;
   assign push_sum  = req_fire && req_data.last_byte;

   // build the held core report and the frame summary
   always_comb begin
      code       = held_ff[2:0] & ctfc_pkg::CORE_CODE_MASK;
      flags_core = flags_ff;
      if (held_valid_ff) begin
         if (code == ctfc_pkg::CORE_OPEN)     flags_core[ctfc_pkg::FLAG_OPEN]    = 1'b1;
         if (code == ctfc_pkg::CORE_SHORT)    flags_core[ctfc_pkg::FLAG_SHORT]   = 1'b1;
         if (code == ctfc_pkg::CORE_MISWIRED) flags_core[ctfc_pkg::FLAG_MISWIRE] = 1'b1;
      end

      core_rsp                = '0;
      core_rsp.report_kind    = ctfc_pkg::KIND_CORE;
      core_rsp.core_index     = count_ff + 8'd1;
      core_rsp.core_state     = (code > ctfc_pkg::CORE_NOT_CONN) ? ctfc_pkg::CORE_UNKNOWN
                                                                 : code;
      core_rsp.miswire_target = held_ff[7:3];
      core_rsp.cable_number   = cable_ff;
      core_rsp.last_of_run    = !req_data.last_byte;

      crc_match             = (req_data.data_byte == crc_ff);
      sum_rsp               = '0;
      sum_rsp.report_kind   = ctfc_pkg::KIND_SUMMARY;
      sum_rsp.cable_number  = (pos_ff == ctfc_pkg::POS_CABLE) ? req_data.data_byte : cable_ff;
      sum_rsp.crc_ok        = crc_match;
      sum_rsp.any_open      = flags_core[ctfc_pkg::FLAG_OPEN];
      sum_rsp.any_short     = flags_core[ctfc_pkg::FLAG_SHORT];
      sum_rsp.any_miswire   = flags_core[ctfc_pkg::FLAG_MISWIRE];
      sum_rsp.cable_healthy = crc_match && (flags_core == 3'b000);
      sum_rsp.last_of_run   = 1'b1;
   end

   // frame state next values
   always_comb begin
      crc_in        = crc_ff;
      pos_in        = pos_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      cable_in      = cable_ff;
      count_in      = count_ff;
      flags_in      = flags_ff;
      if (req_fire) begin
         if (held_valid_ff) begin
            count_in      = count_ff + 8'd1;
            flags_in      = flags_core;
            held_valid_in = 1'b0;
         end
         if (req_data.last_byte) begin
            // frame ends: drop all frame state
            crc_in        = '0;
            pos_in        = '0;
            held_in       = '0;
            held_valid_in = 1'b0;
            cable_in      = '0;
            count_in      = '0;
            flags_in      = '0;
         end else begin
            crc_in = ctfc_pkg::crc8_update(crc_ff, req_data.data_byte);
            if (pos_ff == ctfc_pkg::POS_CABLE) cable_in = req_data.data_byte;
            if (pos_ff >= ctfc_pkg::POS_CORE) begin
               held_in       = req_data.data_byte;
               held_valid_in = 1'b1;
            end
            if (pos_ff < ctfc_pkg::POS_SAT) pos_in = pos_ff + 3'd1;
         end
      end
   end

   // queue pointer and fill next values
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push_core && push_sum)  wr_ptr_in = ptr_next(ptr_next(wr_ptr_ff));
      else if (push_core || push_sum) wr_ptr_in = ptr_next(wr_ptr_ff);
      rd_ptr_in = rsp_fire ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push_core} + {1'b0, push_sum} - {1'b0, rsp_fire};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff        <= '0;
         pos_ff        <= '0;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         cable_ff      <= '0;
         count_ff      <= '0;
         flags_ff      <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fill_ff       <= '0;
      end else begin
         crc_ff        <= crc_in;
         pos_ff        <= pos_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         cable_ff      <= cable_in;
         count_ff      <= count_in;
         flags_ff      <= flags_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         fill_ff       <= fill_in;
      end
   end

   // queue storage: core report first, summary behind it
   always_ff @(posedge clock) begin
      if (push_core) queue_ff[wr_ptr_ff] <= core_rsp;
      if (push_sum) begin
         if (push_core) queue_ff[ptr_next(wr_ptr_ff)] <= sum_rsp;
         else           queue_ff[wr_ptr_ff]           <= sum_rsp;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff != QUEUE_FULL || !req_ready)
      else $error("queue accepts a byte while full");

   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.last_byte |=> !held_valid_ff && pos_ff == 3'd0 && count_ff == 8'd0)
      else $error("frame state not cleared after CRC byte");

   a_core_hold: assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_data.last_byte && pos_ff >= ctfc_pkg::POS_CORE |=> held_valid_ff)
      else $error("core byte not held");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for cable_test_frame_checker: drives frame bytes on the
// req channel, predicts every core report and frame summary, and checks the rsp channel.
// Depends on ctfc_pkg and the cable_test_frame_checker RTL.
module tb_top;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   ctfc_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   ctfc_pkg::rsp_type rsp_data;

   cable_test_frame_checker i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Free-running clock, 12 time units per period.
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Shadow copy of the frame parser state, updated on every accepted req beat.
   logic [7:0] shadow_crc;
   logic [2:0] shadow_pos;
   logic [7:0] shadow_held;
   logic       shadow_held_valid;
   logic [7:0] shadow_cable;
   logic [7:0] shadow_core_count;
   logic [2:0] shadow_flags;

   // Reports the block still owes us, oldest first.
   ctfc_pkg::rsp_type pending_reports[$];
   ctfc_pkg::rsp_type oldest_report;

   // Bytes of the next frame before its CRC byte.
   logic [7:0] frame_body[$];

   int  error_count     = 0;
   int  beats_sent      = 0;
   int  frames_sent     = 0;
   int  reports_checked = 0;
   bit  quiet           = 1'b0; // set for a stretch with no idling on either side

   // CRC-8, polynomial x^8 + x^2 + x + 1, MSB first, zero init.
   function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] acc;
      acc = crc ^ b;
      repeat (8) begin
         if (acc[7]) acc = (acc << 1) ^ 8'h07;
         else        acc = acc << 1;
      end
      return acc;
   endfunction

   function automatic void clear_shadow();
      shadow_crc        = '0;
      shadow_pos        = '0;
      shadow_held       = '0;
      shadow_held_valid = 1'b0;
      shadow_cable      = '0;
      shadow_core_count = '0;
      shadow_flags      = '0;
   endfunction

   // Work out the reports that one accepted frame byte releases and queue them.
   function automatic void decode_frame_byte(input ctfc_pkg::req_type beat);
      ctfc_pkg::rsp_type core_rpt;
      ctfc_pkg::rsp_type summary;
      logic [2:0]        code;
      bit                released;
      bit                crc_match;
      released = 1'b0;
      core_rpt = '0;
      summary  = '0;
      // A held core byte leaves now: this byte proves it was not the CRC.
      if (shadow_held_valid) begin
         code = shadow_held[2:0] & ctfc_pkg::CORE_CODE_MASK;
         shadow_core_count      = shadow_core_count + 8'd1;
         core_rpt.report_kind   = ctfc_pkg::KIND_CORE;
         core_rpt.core_index    = shadow_core_count;
         core_rpt.core_state    = (code > ctfc_pkg::CORE_NOT_CONN) ? ctfc_pkg::CORE_UNKNOWN
                                                                   : code;
         core_rpt.miswire_target = shadow_held[7:3];
         core_rpt.cable_number  = shadow_cable;
         if (code == ctfc_pkg::CORE_OPEN)     shadow_flags[ctfc_pkg::FLAG_OPEN]    = 1'b1;
         if (code == ctfc_pkg::CORE_SHORT)    shadow_flags[ctfc_pkg::FLAG_SHORT]   = 1'b1;
         if (code == ctfc_pkg::CORE_MISWIRED) shadow_flags[ctfc_pkg::FLAG_MISWIRE] = 1'b1;
         shadow_held_valid = 1'b0;
         released = 1'b1;
      end
      if (!beat.last_byte) begin
         shadow_crc = crc8_next(shadow_crc, beat.data_byte);
         if (shadow_pos == ctfc_pkg::POS_CABLE) shadow_cable = beat.data_byte;
         if (shadow_pos >= ctfc_pkg::POS_CORE) begin
            shadow_held       = beat.data_byte;
            shadow_held_valid = 1'b1;
         end
         if (shadow_pos < ctfc_pkg::POS_SAT) shadow_pos = shadow_pos + 3'd1;
         if (released) begin
            core_rpt.last_of_run = 1'b1;
            pending_reports.push_back(core_rpt);
         end
      end else begin
         if (released) pending_reports.push_back(core_rpt);
         crc_match = (beat.data_byte == shadow_crc);
         summary.report_kind   = ctfc_pkg::KIND_SUMMARY;
         // A CRC at index two doubles as the cable number.
         summary.cable_number  = (shadow_pos == ctfc_pkg::POS_CABLE) ? beat.data_byte
                                                                     : shadow_cable;
         summary.crc_ok        = crc_match;
         summary.any_open      = shadow_flags[ctfc_pkg::FLAG_OPEN];
         summary.any_short     = shadow_flags[ctfc_pkg::FLAG_SHORT];
         summary.any_miswire   = shadow_flags[ctfc_pkg::FLAG_MISWIRE];
         summary.cable_healthy = crc_match && (shadow_flags == 3'b000);
         summary.last_of_run   = 1'b1;
         pending_reports.push_back(summary);
         clear_shadow();
      end
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Scoreboard: check the rsp beat first (it belongs to earlier bytes),
   // then predict from the req beat taken at this same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_reports.size() == 0) begin
               $error("report with nothing expected: kind %0d index %0d",
                      rsp_data.report_kind, rsp_data.core_index);
               error_count++;
            end else begin
               oldest_report = pending_reports.pop_front();
               reports_checked++;
               check_field("report_kind", oldest_report.report_kind, rsp_data.report_kind);
               check_field("core_index", oldest_report.core_index, rsp_data.core_index);
               check_field("core_state", oldest_report.core_state, rsp_data.core_state);
               check_field("miswire_target", oldest_report.miswire_target,
                           rsp_data.miswire_target);
               check_field("cable_number", oldest_report.cable_number, rsp_data.cable_number);
               check_field("crc_ok", oldest_report.crc_ok, rsp_data.crc_ok);
               check_field("any_open", oldest_report.any_open, rsp_data.any_open);
               check_field("any_short", oldest_report.any_short, rsp_data.any_short);
               check_field("any_miswire", oldest_report.any_miswire, rsp_data.any_miswire);
               check_field("cable_healthy", oldest_report.cable_healthy,
                           rsp_data.cable_healthy);
               check_field("last_of_run", oldest_report.last_of_run, rsp_data.last_of_run);
            end
         end
         if (req_valid && req_ready) decode_frame_byte(req_data);
      end
   end

   // Receiver back-pressure: drop ready at random, about 12 percent of the time, except while quiet is set.
   always @(negedge clock) begin
      rsp_ready <= quiet || ($urandom_range(0, 99) >= 12);
   end

   // Send one beat: idle at random first, then hold valid and payload until accepted.
   task automatic send_byte(input logic [7:0] b, input bit last);
      @(negedge clock);
      while (!quiet && $urandom_range(0, 99) < 12) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_data.data_byte <= b;
      req_data.last_byte <= last;
      @(posedge clock);
      while (!(req_valid && req_ready)) @(posedge clock);
      beats_sent++;
   endtask

   // Send frame_body followed by its CRC, corrupted on request.
   task automatic send_frame(input bit corrupt);
      logic [7:0] crc;
      crc = '0;
      foreach (frame_body[i]) begin
         crc = crc8_next(crc, frame_body[i]);
         send_byte(frame_body[i], 1'b0);
      end
      if (corrupt) crc = crc ^ 8'($urandom_range(1, 255));
      send_byte(crc, 1'b1);
      frames_sent++;
   endtask

   // Drop valid and hold the sender until every owed report has come out.
   task automatic drain_reports();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   // CRC at index zero, one and two: no cores, and index two gives the cable number.
   task automatic test_short_frames();
      frame_body.delete();
      send_frame(1'b0);
      send_frame(1'b1);
      frame_body = '{8'hFF};
      send_frame(1'b0);
      frame_body = '{8'h00, 8'hA5};
      send_frame(1'b0);
   endtask

   // Every core code, including the unknown ones, with extreme byte values.
   task automatic test_core_codes();
      frame_body = '{8'h00, 8'hFF, 8'hFF,
                     8'h00, 8'h09, 8'h12, 8'h1B, 8'h24, 8'h2D, 8'h36, 8'hFF};
      send_frame(1'b0);
      drain_reports();
   endtask

   // Faults on a frame whose CRC fails: reports stand, summary is unhealthy.
   task automatic test_crc_failure();
      frame_body = '{8'h5A, 8'hC3, 8'h00, 8'h03, 8'hFA};
      send_frame(1'b1);
   endtask

   // More than 255 cores in one frame: the core index wraps.
   task automatic test_core_wrap();
      frame_body = '{8'h01, 8'h02, 8'h7E};
      repeat (262) frame_body.push_back(8'($urandom_range(0, 255)));
      send_frame(1'b0);
   endtask

   // Random frames, mostly well formed, some with a bad CRC, some pure noise.
   task automatic test_random_frames();
      int n_cores;
      int n_noise;
      int frame_no;
      int start_beats;
      bit noise_last;
      frame_no    = 0;
      start_beats = beats_sent;
      while (beats_sent - start_beats < 400) begin
         quiet = (frame_no >= 20 && frame_no < 36);
         if ($urandom_range(0, 99) < 10) begin
            // Noise: random bytes with random ends, closed by a CRC beat.
            n_noise = $urandom_range(1, 8);
            for (int i = 0; i < n_noise; i++) begin
               noise_last = ($urandom_range(0, 3) == 0) || (i == n_noise - 1);
               send_byte(8'($urandom_range(0, 255)), noise_last);
            end
         end else begin
            frame_body.delete();
            if ($urandom_range(0, 99) < 10) begin
               repeat ($urandom_range(0, 2)) frame_body.push_back(8'($urandom_range(0, 255)));
            end else begin
               n_cores = $urandom_range(0, 10);
               repeat (3 + n_cores) frame_body.push_back(8'($urandom_range(0, 255)));
            end
            send_frame($urandom_range(0, 99) < 20);
         end
         if (frame_no % 9 == 8) drain_reports();
         frame_no++;
      end
      quiet = 1'b0;
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      clear_shadow();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_short_frames();
      test_core_codes();
      test_crc_failure();
      test_core_wrap();
      test_random_frames();

      // Drain, then keep the clock running so that any stray report shows before the summary.
      drain_reports();
      repeat (20) @(posedge clock);
      $display("Sent %0d beats in %0d frames (short, wrapping, noisy, bad CRC);",
               beats_sent, frames_sent);
      $display("checked %0d core reports and summaries under random back-pressure.",
               reports_checked);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog well past the slowest legal run.
   initial begin
      #3000000;
      $display("timeout: %0d reports still owed", pending_reports.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule
